>>> design/rpn_truth_table_evaluator_assert.svh
// Assertion macros for the postfix evaluator.
// Each macro takes a label, the clock, the active-low reset and a property.
`ifndef RPN_TRUTH_TABLE_EVALUATOR_ASSERT_SVH
`define RPN_TRUTH_TABLE_EVALUATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define RTE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define RTE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define RTE_ASSERT(lbl, clk, rst_n, prop)
`define RTE_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> design/rte_pkg.sv
`timescale 1ns / 1ps
package rte_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADCHAR  = 3'd1;
  localparam logic [2:0] ST_OPERAND  = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_DEPTH    = 3'd4;
  localparam logic [2:0] ST_NOTERM   = 3'd5;

  localparam logic [15:0] VEC_A = 16'hFF00;
  localparam logic [15:0] VEC_B = 16'hF0F0;
  localparam logic [15:0] VEC_C = 16'hCCCC;
  localparam logic [15:0] VEC_D = 16'hAAAA;
  localparam logic [15:0] VEC_T = 16'hFFFF;
  localparam logic [15:0] VEC_F = 16'h0000;

  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [3:0] {
    OP_SKIP,
    OP_PUSH,
    OP_INV,
    OP_AND,
    OP_OR,
    OP_XOR,
    OP_TERM,
    OP_EOT,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] vec;
  } dec_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] true_mask;
    logic [15:0] dont_care_mask;
  } out_t;

endpackage

>>> design/rte_decode.sv
`timescale 1ns / 1ps
module rte_decode (
  input  rte_pkg::in_t  beat,
  output rte_pkg::dec_t dec
);

  always_comb begin
    dec.op  = rte_pkg::OP_BAD;
    dec.vec = rte_pkg::VEC_F;
    if (beat.end_of_text) begin
      dec.op = rte_pkg::OP_EOT;
    end else if (beat.char_code == 8'(";")) begin
      dec.op = rte_pkg::OP_TERM;
    end else if (beat.char_code <= rte_pkg::CH_SPACE || beat.char_code[7]) begin
      // control bytes, space and the upper half read as whitespace
      dec.op = rte_pkg::OP_SKIP;
    end else begin
      case (beat.char_code)
        8'("a"), 8'("A"): begin
          dec.op  = rte_pkg::OP_PUSH;
          dec.vec = rte_pkg::VEC_A;
        end
        8'("b"), 8'("B"): begin
          dec.op  = rte_pkg::OP_PUSH;
          dec.vec = rte_pkg::VEC_B;
        end
        8'("c"), 8'("C"): begin
          dec.op  = rte_pkg::OP_PUSH;
          dec.vec = rte_pkg::VEC_C;
        end
        8'("d"), 8'("D"): begin
          dec.op  = rte_pkg::OP_PUSH;
          dec.vec = rte_pkg::VEC_D;
        end
        8'("t"), 8'("T"): begin
          dec.op  = rte_pkg::OP_PUSH;
          dec.vec = rte_pkg::VEC_T;
        end
        8'("f"), 8'("F"): begin
          dec.op  = rte_pkg::OP_PUSH;
          dec.vec = rte_pkg::VEC_F;
        end
        8'("!"), 8'("~"): dec.op = rte_pkg::OP_INV;
        8'("&"):          dec.op = rte_pkg::OP_AND;
        8'("|"):          dec.op = rte_pkg::OP_OR;
        8'("^"):          dec.op = rte_pkg::OP_XOR;
        default:          dec.op = rte_pkg::OP_BAD;
      endcase
    end
  end

endmodule

>>> design/rte_core.sv
`timescale 1ns / 1ps
module rte_core (
  input  logic          clk,
  input  logic          rst_n,
  input  rte_pkg::dec_t dec,
  input  logic          adv,
  output rte_pkg::out_t res,
  output logic          res_vld
);

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_PUSH,
    ACT_SET_TOP,
    ACT_POP
  } act_t;

  localparam logic [rte_pkg::DEPTH_W-1:0] DEPTH_FULL = rte_pkg::DEPTH_W'(rte_pkg::STACK_DEPTH);
  localparam logic [rte_pkg::DEPTH_W-1:0] DEPTH_ONE  = rte_pkg::DEPTH_W'(1);
  localparam logic [rte_pkg::DEPTH_W-1:0] DEPTH_TWO  = rte_pkg::DEPTH_W'(2);

  // entry 0 is the top of stack; push shifts down, pop shifts up
  logic [15:0]                  stk_r [rte_pkg::STACK_DEPTH];
  logic [rte_pkg::DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [2:0]                   err_r, err_nxt;
  act_t                         act;
  logic [15:0]                  top_nxt;

  always_comb begin
    depth_nxt = depth_r;
    err_nxt   = err_r;
    act       = ACT_HOLD;
    top_nxt   = dec.vec;
    res       = '0;
    res_vld   = 1'b0;
    case (dec.op)
      rte_pkg::OP_EOT: begin
        res_vld    = 1'b1;
        res.status = (err_r != rte_pkg::ST_OK) ? err_r : rte_pkg::ST_NOTERM;
        depth_nxt  = '0;
        err_nxt    = rte_pkg::ST_OK;
      end
      rte_pkg::OP_TERM: begin
        res_vld   = 1'b1;
        depth_nxt = '0;
        err_nxt   = rte_pkg::ST_OK;
        if (err_r != rte_pkg::ST_OK) begin
          res.status = err_r;
        end else if (depth_r == DEPTH_ONE) begin
          res.status    = rte_pkg::ST_OK;
          res.true_mask = stk_r[0];
        end else if (depth_r == DEPTH_TWO) begin
          res.status         = rte_pkg::ST_OK;
          res.true_mask      = stk_r[1] & stk_r[0];
          res.dont_care_mask = ~stk_r[0];
        end else begin
          res.status = rte_pkg::ST_DEPTH;
        end
      end
      rte_pkg::OP_PUSH: begin
        if (err_r == rte_pkg::ST_OK) begin
          if (depth_r == DEPTH_FULL) begin
            err_nxt = rte_pkg::ST_OVERFLOW;
          end else begin
            act       = ACT_PUSH;
            depth_nxt = depth_r + DEPTH_ONE;
          end
        end
      end
      rte_pkg::OP_INV: begin
        if (err_r == rte_pkg::ST_OK) begin
          if (depth_r < DEPTH_ONE) begin
            err_nxt = rte_pkg::ST_OPERAND;
          end else begin
            act     = ACT_SET_TOP;
            top_nxt = ~stk_r[0];
          end
        end
      end
      rte_pkg::OP_AND, rte_pkg::OP_OR, rte_pkg::OP_XOR: begin
        if (err_r == rte_pkg::ST_OK) begin
          if (depth_r < DEPTH_TWO) begin
            err_nxt = rte_pkg::ST_OPERAND;
          end else begin
            act       = ACT_POP;
            depth_nxt = depth_r - DEPTH_ONE;
            if (dec.op == rte_pkg::OP_AND) begin
              top_nxt = stk_r[1] & stk_r[0];
            end else if (dec.op == rte_pkg::OP_OR) begin
              top_nxt = stk_r[1] | stk_r[0];
            end else begin
              top_nxt = stk_r[1] ^ stk_r[0];
            end
          end
        end
      end
      rte_pkg::OP_BAD: begin
        if (err_r == rte_pkg::ST_OK) begin
          err_nxt = rte_pkg::ST_BADCHAR;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      err_r   <= rte_pkg::ST_OK;
    end else if (adv) begin
      depth_r <= depth_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      case (act)
        ACT_PUSH: begin
          stk_r[0] <= top_nxt;
          for (int i = 1; i < rte_pkg::STACK_DEPTH; i++) begin
            stk_r[i] <= stk_r[i-1];
          end
        end
        ACT_SET_TOP: stk_r[0] <= top_nxt;
        ACT_POP: begin
          stk_r[0] <= top_nxt;
          for (int i = 1; i < rte_pkg::STACK_DEPTH - 1; i++) begin
            stk_r[i] <= stk_r[i+1];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> design/rpn_truth_table_evaluator.sv
`timescale 1ns / 1ps
// Postfix boolean evaluator over a..d, 16 truth combinations per vector.
// A beat is accepted into the input register and executed from there; its result,
// if any, goes into the output register, and an output stall holds both back.
// Throughput: one character per cycle unless a result is stalled; the single
// execute stage updates the shift-register vector stack from the input register.
// Reset: synchronous, active low; clears valid flags, stack depth and error.
// Stack contents are not cleared.
`include "rpn_truth_table_evaluator_assert.svh"
module rpn_truth_table_evaluator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rte_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rte_pkg::out_t out_data
);

  rte_pkg::in_t  in_r;
  logic          in_vld_r, in_vld_nxt;
  rte_pkg::out_t out_r;
  logic          out_vld_r, out_vld_nxt;
  rte_pkg::dec_t dec;
  rte_pkg::out_t res;
  logic          res_vld;
  logic          adv;
  logic          in_acc;

  // execute when the result slot is free or drains this cycle
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv && res_vld) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
    if (adv && res_vld) begin
      out_r <= res;
    end
  end

  rte_decode u_decode (
    .beat (in_r),
    .dec  (dec)
  );

  rte_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .dec     (dec),
    .adv     (adv),
    .res     (res),
    .res_vld (res_vld)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `RTE_ASSERT(a_err_masks_zero, clk, rst_n, (out_vld_r && out_r.status != rte_pkg::ST_OK) |-> (out_r.true_mask == 16'h0 && out_r.dont_care_mask == 16'h0))
  `RTE_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> (in_vld_r && out_vld_r && out_stall))
  `RTE_ASSERT(a_accept_loads, clk, rst_n, in_acc |=> in_vld_r)
  `RTE_ASSERT_NEVER(a_bad_status, clk, rst_n, out_vld_r && out_r.status > rte_pkg::ST_NOTERM)

endmodule
